/* design/txc_pkg.sv */
package txc_pkg;

    // Defaults for the top-level parameters
    localparam int GLYPH_ROWS_DEF  = 16;
    localparam int CELL_PITCH_DEF  = 9;
    localparam int GLYPH_COUNT_DEF = 256;

    // Field widths
    localparam int OP_W    = 2;
    localparam int CODE_W  = 8;
    localparam int GROW_W  = 4;
    localparam int MASK_W  = 8;
    localparam int COLOR_W = 24;
    localparam int COORD_W = 12;
    localparam int DIM_W   = 13;
    localparam int COL_W   = 9;
    localparam int LINE_W  = 8;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;
    localparam logic [DIM_W-1:0] SCREEN_WIDTH_RST  = 13'd640;
    localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RST = 13'd480;

    // Input operations
    localparam logic [OP_W-1:0] OP_PRINT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_W-1:0] OP_HOME  = 2'd2;

    // Result kinds
    localparam logic KIND_ROW   = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_CLEAR_NL,
        ST_ROWS
    } state_t;

    typedef struct packed {
        logic sel_input;    // font read address follows the input char_code
        logic font_write;
        logic home;
        logic start_print;
        logic emit_clear;
        logic clear_last;
        logic emit_row;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            newline;
        logic            move;
        logic            clear_due;
        logic            last_row;
        logic            out_free;
    } stat_t;

endpackage

/* design/txc_in_if.sv */
interface txc_in_if;
    import txc_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [CODE_W-1:0]  char_code;
    logic [GROW_W-1:0]  glyph_row;
    logic [MASK_W-1:0]  row_bits;
    logic [COLOR_W-1:0] ink_color;

    modport source (output valid, op, char_code, glyph_row, row_bits, ink_color,
                    input ready);
    modport sink (input valid, op, char_code, glyph_row, row_bits, ink_color,
                  output ready);
endinterface

/* design/txc_out_if.sv */
interface txc_out_if;
    import txc_pkg::*;

    logic               valid;
    logic               ready;
    logic               kind;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [MASK_W-1:0]  row_mask;
    logic [COLOR_W-1:0] pixel_color;
    logic               last;

    modport source (output valid, kind, pixel_x, pixel_y, row_mask, pixel_color, last,
                    input ready);
    modport sink (input valid, kind, pixel_x, pixel_y, row_mask, pixel_color, last,
                  output ready);
endinterface

/* design/txc_ram.sv */
module txc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* design/txc_cfg.sv */
module txc_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [txc_pkg::PADDR_W-1:0]   paddr,
    input  logic [txc_pkg::PDATA_W-1:0]   pwdata,
    output logic [txc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output logic [txc_pkg::DIM_W-1:0]     screen_width,
    output logic [txc_pkg::DIM_W-1:0]     screen_height
);
    import txc_pkg::*;

    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    logic             wr_en;
    logic             reg_sel;

    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_SCREEN_WIDTH:  width_next  = pwdata[DIM_W-1:0];
                REG_SCREEN_HEIGHT: height_next = pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SCREEN_WIDTH_RST;
            height_reg <= SCREEN_HEIGHT_RST;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    assign prdata = (reg_sel == REG_SCREEN_HEIGHT) ? PDATA_W'(height_reg)
                                                   : PDATA_W'(width_reg);
    assign pready        = 1'b1;
    assign screen_width  = width_reg;
    assign screen_height = height_reg;
endmodule

/* design/txc_ctrl.sv */
module txc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  txc_pkg::stat_t stat,
    output txc_pkg::cmd_t  cmd
);
    import txc_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.sel_input = 1'b1;
                if (in_valid)
                begin
                    case (stat.op)
                        OP_LOAD: cmd.font_write = 1'b1;
                        OP_HOME: cmd.home = 1'b1;
                        OP_PRINT:
                        begin
                            cmd.start_print = 1'b1;
                            if (stat.newline)
                            begin
                                if (stat.clear_due)
                                begin
                                    state_next = ST_CLEAR_NL;
                                end
                            end
                            else if (stat.move && stat.clear_due)
                            begin
                                state_next = ST_CLEAR;
                            end
                            else
                            begin
                                state_next = ST_ROWS;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_clear = 1'b1;
                    state_next     = ST_ROWS;
                end
            end
            ST_CLEAR_NL:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_clear = 1'b1;
                    cmd.clear_last = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_ROWS:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_row = 1'b1;
                    if (stat.last_row)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

/* design/txc_dpath.sv */
module txc_dpath #(
    parameter int GLYPH_ROWS  = txc_pkg::GLYPH_ROWS_DEF,
    parameter int CELL_PITCH  = txc_pkg::CELL_PITCH_DEF,
    parameter int GLYPH_COUNT = txc_pkg::GLYPH_COUNT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  txc_pkg::cmd_t               cmd,
    output txc_pkg::stat_t              stat,
    input  logic [txc_pkg::DIM_W-1:0]   screen_width,
    input  logic [txc_pkg::DIM_W-1:0]   screen_height,
    input  logic [txc_pkg::OP_W-1:0]    op,
    input  logic [txc_pkg::CODE_W-1:0]  char_code,
    input  logic [txc_pkg::GROW_W-1:0]  glyph_row,
    input  logic [txc_pkg::MASK_W-1:0]  row_bits,
    input  logic [txc_pkg::COLOR_W-1:0] ink_color,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic                        kind,
    output logic [txc_pkg::COORD_W-1:0] pixel_x,
    output logic [txc_pkg::COORD_W-1:0] pixel_y,
    output logic [txc_pkg::MASK_W-1:0]  row_mask,
    output logic [txc_pkg::COLOR_W-1:0] pixel_color,
    output logic                        last
);
    import txc_pkg::*;

    localparam int FONT_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
    localparam int AW         = $clog2(FONT_DEPTH);
    localparam int RW         = $clog2(GLYPH_ROWS);
    localparam int GEO_W      = DIM_W + 1;

    // Cursor and per-item state
    logic [COL_W-1:0]   col_reg, col_next;
    logic [LINE_W-1:0]  line_reg, line_next;
    logic [RW-1:0]      row_reg, row_next;
    logic [AW-1:0]      base_reg, base_next;
    logic               code_ok_reg, code_ok_next;
    logic [COLOR_W-1:0] color_reg, color_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic               kind_reg, kind_next;
    logic [COORD_W-1:0] x_reg, x_next;
    logic [COORD_W-1:0] y_reg, y_next;
    logic [MASK_W-1:0]  mask_reg, mask_next;
    logic [COLOR_W-1:0] pcolor_reg, pcolor_next;
    logic               last_reg, last_next;

    logic [AW-1:0]      in_base;
    logic [AW-1:0]      font_waddr;
    logic [AW-1:0]      font_raddr;
    logic [MASK_W-1:0]  font_rdata;
    logic               load_ok;
    logic               in_code_ok;
    logic [GEO_W-1:0]   cell_right;
    logic [GEO_W-1:0]   next_top;
    logic               wrap;

    assign in_code_ok = {1'b0, char_code} < (CODE_W + 1)'(GLYPH_COUNT);
    assign load_ok    = in_code_ok && ({2'b00, glyph_row} < (GROW_W + 2)'(GLYPH_ROWS));
    assign in_base    = AW'(char_code * GLYPH_ROWS);
    assign font_waddr = AW'(in_base + AW'(glyph_row));

    // Geometry checks on the current cursor
    assign cell_right = GEO_W'(col_reg * CELL_PITCH) + GEO_W'(CELL_PITCH);
    assign next_top   = GEO_W'((LINE_W + 1)'(line_reg) + 1'b1) * GEO_W'(GLYPH_ROWS);
    assign wrap       = cell_right > {1'b0, screen_width};

    assign stat.op        = op;
    assign stat.newline   = char_code == NEWLINE_CODE;
    assign stat.move      = (char_code == NEWLINE_CODE) || wrap;
    assign stat.clear_due = next_top >= {1'b0, screen_height};
    assign stat.last_row  = row_reg == RW'(GLYPH_ROWS - 1);
    assign stat.out_free  = !out_valid_reg || out_ready;

    // Read one row ahead so that a row can leave every cycle while the output is not stalled
    assign font_raddr = cmd.sel_input ? in_base
                      : AW'(base_reg + AW'(row_reg) + AW'(cmd.emit_row));

    txc_ram #(
        .WIDTH (MASK_W),
        .DEPTH (FONT_DEPTH)
    ) u_font (
        .clk   (clk),
        .we    (cmd.font_write && load_ok),
        .waddr (font_waddr),
        .wdata (row_bits),
        .raddr (font_raddr),
        .rdata (font_rdata)
    );

    always_comb
    begin
        col_next     = col_reg;
        line_next    = line_reg;
        row_next     = row_reg;
        base_next    = base_reg;
        code_ok_next = code_ok_reg;
        color_next   = color_reg;

        if (cmd.home)
        begin
            col_next  = '0;
            line_next = '0;
        end
        if (cmd.start_print)
        begin
            base_next    = in_base;
            code_ok_next = in_code_ok;
            color_next   = ink_color;
            row_next     = '0;
            if (stat.move)
            begin
                col_next  = '0;
                line_next = stat.clear_due ? '0 : LINE_W'(line_reg + 1'b1);
            end
        end
        if (cmd.emit_row)
        begin
            row_next = RW'(row_reg + 1'b1);
            if (stat.last_row)
            begin
                col_next = COL_W'(col_reg + 1'b1);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        mask_next      = mask_reg;
        pcolor_next    = pcolor_reg;
        last_next      = last_reg;
        if (cmd.emit_clear)
        begin
            out_valid_next = 1'b1;
            kind_next      = KIND_CLEAR;
            x_next         = '0;
            y_next         = '0;
            mask_next      = '0;
            pcolor_next    = '0;
            last_next      = cmd.clear_last;
        end
        else if (cmd.emit_row)
        begin
            out_valid_next = 1'b1;
            kind_next      = KIND_ROW;
            x_next         = COORD_W'(col_reg * CELL_PITCH);
            y_next         = COORD_W'(line_reg * GLYPH_ROWS + row_reg);
            mask_next      = code_ok_reg ? font_rdata : '0;
            pcolor_next    = color_reg;
            last_next      = stat.last_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            line_reg      <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            line_reg      <= line_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg    <= base_next;
        code_ok_reg <= code_ok_next;
        color_reg   <= color_next;
        kind_reg    <= kind_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        mask_reg    <= mask_next;
        pcolor_reg  <= pcolor_next;
        last_reg    <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign pixel_x     = x_reg;
    assign pixel_y     = y_reg;
    assign row_mask    = mask_reg;
    assign pixel_color = pcolor_reg;
    assign last        = last_reg;
endmodule

/* design/text_console_glyph_renderer.sv */
// Text console glyph renderer. Each input item is a print, a font row load or
// a cursor home. A print turns one character into GLYPH_ROWS row writes (bit 7
// of row_mask is the leftmost pixel, pixel_x is the cell's left edge), preceded
// by a clear-screen item when a line wrap runs past the bottom of the screen;
// a newline gives a single clear item only when it runs past the bottom, and
// nothing otherwise. The final item caused by an input carries last. A
// printed character holds off the next input until its clear and glyph rows
// have been sent. The font RAM has a single read port, which delivers one
// glyph row per cycle while the output is not stalled; a stalled output side
// holds up the rows. A newline that clears holds off the next input until its
// clear item has been sent. The font RAM holds no reset value: print only
// glyph rows that have been loaded. screen_width and screen_height sit at
// byte addresses 0 and 4 of the APB port and should be written while idle.
module text_console_glyph_renderer #(
    parameter int GLYPH_ROWS  = txc_pkg::GLYPH_ROWS_DEF,
    parameter int CELL_PITCH  = txc_pkg::CELL_PITCH_DEF,
    parameter int GLYPH_COUNT = txc_pkg::GLYPH_COUNT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    txc_in_if.sink                      in_ch,
    txc_out_if.source                   out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [txc_pkg::PADDR_W-1:0] paddr,
    input  logic [txc_pkg::PDATA_W-1:0] pwdata,
    output logic [txc_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import txc_pkg::*;

    cmd_t             cmd;
    stat_t            stat;
    logic [DIM_W-1:0] screen_width;
    logic [DIM_W-1:0] screen_height;
    logic             in_ready;

    // Screen size registers behind the APB port
    txc_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .screen_width  (screen_width),
        .screen_height (screen_height)
    );

    // Sequencer: takes an item in idle, then walks through clear and glyph rows
    txc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    assign in_ch.ready = in_ready;

    // Cursor, font RAM, geometry checks and the output register.
    // The output register lets a new item be taken while a result waits.
    txc_dpath #(
        .GLYPH_ROWS  (GLYPH_ROWS),
        .CELL_PITCH  (CELL_PITCH),
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .screen_width  (screen_width),
        .screen_height (screen_height),
        .op            (in_ch.op),
        .char_code     (in_ch.char_code),
        .glyph_row     (in_ch.glyph_row),
        .row_bits      (in_ch.row_bits),
        .ink_color     (in_ch.ink_color),
        .out_ready     (out_ch.ready),
        .out_valid     (out_ch.valid),
        .kind          (out_ch.kind),
        .pixel_x       (out_ch.pixel_x),
        .pixel_y       (out_ch.pixel_y),
        .row_mask      (out_ch.row_mask),
        .pixel_color   (out_ch.pixel_color),
        .last          (out_ch.last)
    );
endmodule

/* design/txc_checker.sv */
module txc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic [txc_pkg::OP_W-1:0]    op,
    input logic [txc_pkg::CODE_W-1:0]  char_code,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        kind,
    input logic [txc_pkg::COORD_W-1:0] pixel_x,
    input logic [txc_pkg::COORD_W-1:0] pixel_y,
    input logic [txc_pkg::MASK_W-1:0]  row_mask,
    input logic [txc_pkg::COLOR_W-1:0] pixel_color,
    input logic                        last
);
    import txc_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_y) && $stable(row_mask)
                                    && $stable(kind) && $stable(last))
        else $error("result dropped or changed while stalled");

    a_clear_blank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_CLEAR |-> pixel_x == '0 && pixel_y == '0
                                            && row_mask == '0 && pixel_color == '0)
        else $error("clear item carries a nonzero payload");

    a_print_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && op == OP_PRINT && char_code != NEWLINE_CODE |=> !in_ready)
        else $error("new item taken right after a printed character");

    a_mid_glyph: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && kind == KIND_ROW && !last |-> !in_ready)
        else $error("input taken while a glyph is still being sent");
endmodule

bind text_console_glyph_renderer txc_checker u_txc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .op          (in_ch.op),
    .char_code   (in_ch.char_code),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .kind        (out_ch.kind),
    .pixel_x     (out_ch.pixel_x),
    .pixel_y     (out_ch.pixel_y),
    .row_mask    (out_ch.row_mask),
    .pixel_color (out_ch.pixel_color),
    .last        (out_ch.last)
);
